// ----- rtl/kst_pkg.sv -----
// Package for the key state table: sizes, item mode codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package kst_pkg;

   localparam int KEY_COUNT  = 128;
   localparam int TIMER_BITS = 32;

   // key address width and the width that covers both it and the 7-bit index field
   localparam int KEY_BITS = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int IDX_W    = (KEY_BITS > 7) ? KEY_BITS : 7;
   // saturating add and hold compare widths
   localparam int SUM_W    = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
   localparam int CMP_W    = (TIMER_BITS > 32) ? TIMER_BITS : 32;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   typedef enum logic [2:0] {
      MODE_SET    = 3'd0,
      MODE_TICK   = 3'd1,
      MODE_QLEVEL = 3'd2,
      MODE_QFRESH = 3'd3,
      MODE_QHELD  = 3'd4
   } mode_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic eval;
      logic tick_wr;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic walk_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/kst_dpath.sv -----
// Datapath of the key state table: item registers, level/fresh flag vectors,
// hold timer memory with per-entry valid bits, walk counter, answer register.
// Depends on kst_pkg.
`default_nettype none

module kst_dpath (
   input  wire                         clock,
   input  wire                         reset,
   input  wire kst_pkg::ctrl_cmd_type  cmd,
   output kst_pkg::dp_status_type      status,
   input  wire [2:0]                   mode,
   input  wire [6:0]                   key_index,
   input  wire                         key_down,
   input  wire                         keep_fresh,
   input  wire [15:0]                  elapsed_ticks,
   input  wire [31:0]                  hold_limit,
   output logic                        answer
);

   logic [2:0]                     mode_ff;
   logic [6:0]                     key_ff;
   logic                           down_ff;
   logic                           keep_ff;
   logic [15:0]                    dt_ff;
   logic [31:0]                    limit_ff;

   logic [kst_pkg::KEY_COUNT-1:0]  level_ff;
   logic [kst_pkg::KEY_COUNT-1:0]  fresh_ff;
   logic [kst_pkg::KEY_COUNT-1:0]  tvld_ff;
   logic [kst_pkg::TIMER_BITS-1:0] timer_mem [kst_pkg::KEY_COUNT];
   logic [kst_pkg::TIMER_BITS-1:0] rd_data_ff;
   logic                           rd_vld_ff;
   logic [kst_pkg::KEY_BITS-1:0]   cnt_ff;
   logic                           ans_ff;
   logic                           answer_ff;

   logic [kst_pkg::IDX_W-1:0]      key_ext;
   logic [kst_pkg::KEY_BITS-1:0]   key_addr;
   logic                           key_ok;
   logic                           is_tick;
   logic [kst_pkg::KEY_BITS-1:0]   mem_addr;
   logic [kst_pkg::TIMER_BITS-1:0] timer_val;
   logic [kst_pkg::SUM_W-1:0]      sum;
   logic [kst_pkg::TIMER_BITS-1:0] sat_sum;
   logic                           held;
   logic                           cur_level;
   logic                           cur_fresh;
   logic                           fresh_press;
   logic                           mem_we;
   logic [kst_pkg::TIMER_BITS-1:0] mem_wd;

   assign key_ext  = kst_pkg::IDX_W'(key_ff);
   assign key_addr = key_ext[kst_pkg::KEY_BITS-1:0];
   assign key_ok   = {1'b0, key_ext} < (kst_pkg::IDX_W + 1)'(kst_pkg::KEY_COUNT);
   assign is_tick  = (mode_ff == kst_pkg::MODE_TICK);
   assign mem_addr = is_tick ? cnt_ff : key_addr;

   // a timer never written reads as zero
   assign timer_val = rd_vld_ff ? rd_data_ff : '0;
   assign sum       = kst_pkg::SUM_W'(timer_val) + kst_pkg::SUM_W'(dt_ff);
   assign sat_sum   = (sum > kst_pkg::SUM_W'(kst_pkg::TIMER_MAX)) ?
                      kst_pkg::TIMER_MAX : sum[kst_pkg::TIMER_BITS-1:0];
   assign held      = kst_pkg::CMP_W'(timer_val) >= kst_pkg::CMP_W'(limit_ff);

   assign cur_level   = key_ok && level_ff[key_addr];
   assign cur_fresh   = key_ok && fresh_ff[key_addr];
   assign fresh_press = cur_level && cur_fresh;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = sat_sum;
      if (cmd.tick_wr) begin
         mem_we = level_ff[cnt_ff];
      end else if (cmd.eval && key_ok) begin
         mem_wd = '0;
         if (mode_ff == kst_pkg::MODE_SET) begin
            mem_we = (level_ff[key_addr] != down_ff);
         end else if (mode_ff == kst_pkg::MODE_QHELD) begin
            mem_we = !fresh_press && held;
         end
      end
   end

   assign status.is_tick   = is_tick;
   assign status.walk_last = (cnt_ff == kst_pkg::KEY_BITS'(kst_pkg::KEY_COUNT - 1));
   assign answer           = answer_ff;

   // item capture, timer memory, walk counter and result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode;
         key_ff   <= key_index;
         down_ff  <= key_down;
         keep_ff  <= keep_fresh;
         dt_ff    <= elapsed_ticks;
         limit_ff <= hold_limit;
         cnt_ff   <= '0;
         ans_ff   <= 1'b0;
      end
      if (cmd.rd) begin
         rd_data_ff <= timer_mem[mem_addr];
         rd_vld_ff  <= tvld_ff[mem_addr];
      end
      if (mem_we) begin
         timer_mem[mem_addr] <= mem_wd;
      end
      if (cmd.tick_wr) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.eval) begin
         case (mode_ff)
            kst_pkg::MODE_QLEVEL: ans_ff <= cur_level;
            kst_pkg::MODE_QFRESH: ans_ff <= fresh_press;
            kst_pkg::MODE_QHELD:  ans_ff <= key_ok && (fresh_press || held);
            default:              ans_ff <= 1'b0;
         endcase
      end
      if (cmd.out_load) begin
         answer_ff <= ans_ff;
      end
   end

   // flag vectors and timer valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         fresh_ff <= '0;
         tvld_ff  <= '0;
      end else begin
         if (mem_we) begin
            tvld_ff[mem_addr] <= 1'b1;
         end
         if (cmd.eval && key_ok) begin
            case (mode_ff)
               kst_pkg::MODE_SET: begin
                  if (level_ff[key_addr] != down_ff) begin
                     level_ff[key_addr] <= down_ff;
                     fresh_ff[key_addr] <= 1'b1;
                  end
               end
               kst_pkg::MODE_QLEVEL: begin
                  if (!keep_ff) begin
                     fresh_ff[key_addr] <= 1'b0;
                  end
               end
               kst_pkg::MODE_QFRESH, kst_pkg::MODE_QHELD: begin
                  if (fresh_press) begin
                     fresh_ff[key_addr] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kst_ctrl.sv -----
// Controller of the key state table: sequences lookup, update, the timer
// walk of a tick and the result handoff. Depends on kst_pkg.
`default_nettype none

module kst_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output kst_pkg::ctrl_cmd_type       cmd,
   input  wire kst_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_TICK_WR,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   assign cmd.load     = (state_ff == ST_IDLE) && req_tvalid && req_tready_ff;
   assign cmd.rd       = (state_ff == ST_READ);
   assign cmd.eval     = (state_ff == ST_EVAL);
   assign cmd.tick_wr  = (state_ff == ST_TICK_WR);
   assign cmd.out_load = (state_ff == ST_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // drop the taken beat unless a new result replaces it this cycle
         if (rsp_tvalid_ff && rsp_tready && !cmd.out_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready_ff) begin
                  state_ff      <= ST_READ;
                  req_tready_ff <= 1'b0;
               end
            end
            ST_READ: begin
               state_ff <= status.is_tick ? ST_TICK_WR : ST_EVAL;
            end
            ST_EVAL: begin
               state_ff <= ST_DONE;
            end
            ST_TICK_WR: begin
               // advance the walk until the last key is written back
               state_ff <= status.walk_last ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  req_tready_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/key_state_edge_and_repeat_table.sv -----
// Key state table with press-edge latch and hold auto-repeat, top level.
// A key item passes the read, evaluate and done states before its result beat;
// a tick walks every timer through the single memory port, reading and then
// writing back each key in turn. One item is in work at a time.
// Reset (synchronous) clears all levels, fresh flags and timer valid bits.
`default_nettype none

module key_state_edge_and_repeat_table (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [63:0] req_tdata,  // key_index[6:0], key_down[7], keep_fresh[8],
                                  // elapsed_ticks[24:9], hold_limit[56:25], zero[63:57]
   input  wire [2:0]  req_tuser,  // mode[2:0]
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata   // answer[0], zero[7:1]
);

   kst_pkg::ctrl_cmd_type  cmd;
   kst_pkg::dp_status_type status;
   logic                   answer;

   kst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   kst_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .mode          (req_tuser),
      .key_index     (req_tdata[6:0]),
      .key_down      (req_tdata[7]),
      .keep_fresh    (req_tdata[8]),
      .elapsed_ticks (req_tdata[24:9]),
      .hold_limit    (req_tdata[56:25]),
      .answer        (answer)
   );

   assign rsp_tdata = {7'd0, answer};

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");

   a_walk_on_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_wr |-> status.is_tick)
      else $error("timer walk outside a tick item");

   a_eval_not_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> !status.is_tick)
      else $error("key update during a tick item");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for key_state_edge_and_repeat_table: a directed table, then random items.
// Each answer is checked against a hand-fixed value or a local model of the key level, fresh and hold state.
// Depends on kst_pkg and the RTL top level only.
`default_nettype none

module testbench;

   typedef struct {
      logic [2:0]  mode;
      logic [6:0]  key_index;
      logic        key_down;
      logic        keep_fresh;
      logic [15:0] elapsed_ticks;
      logic [31:0] hold_limit;
   } key_item_type;

   typedef struct {
      key_item_type item;
      bit           typed;   // answer below is fixed by hand
      bit           answer;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // key_index[6:0], key_down[7], keep_fresh[8],
                             // elapsed_ticks[24:9], hold_limit[56:25], zero[63:57]
   logic [2:0]  req_tuser;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // answer[0], zero[7:1]

   // local copy of the key table
   bit                             key_level [kst_pkg::KEY_COUNT];
   bit                             key_fresh [kst_pkg::KEY_COUNT];
   logic [kst_pkg::TIMER_BITS-1:0] key_hold  [kst_pkg::KEY_COUNT];

   bit           pending_answers [$];
   plan_row_type plan [$];
   logic [6:0]   hot_keys [6];
   int           items_taken;
   int           errors;
   logic         hold_off;

   key_state_edge_and_repeat_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_fresh_press(int k);
      if (!key_fresh[k] || !key_level[k]) return 1'b0;
      key_fresh[k] = 1'b0;
      return 1'b1;
   endfunction

   // apply one item to the local table and return the answer it should give
   function automatic bit key_table_answer(key_item_type it);
      int k;
      bit ok;
      bit ans;
      logic [kst_pkg::TIMER_BITS:0] sum;
      k = int'(it.key_index);
      ok = (k < kst_pkg::KEY_COUNT);
      ans = 1'b0;
      case (it.mode)
         kst_pkg::MODE_SET: begin
            if (ok && key_level[k] != it.key_down) begin
               key_level[k] = it.key_down;
               key_fresh[k] = 1'b1;
               key_hold[k] = '0;
            end
         end
         kst_pkg::MODE_TICK: begin
            for (int i = 0; i < kst_pkg::KEY_COUNT; i++) begin
               if (key_level[i]) begin
                  sum = key_hold[i] + it.elapsed_ticks;
                  key_hold[i] = sum[kst_pkg::TIMER_BITS] ? kst_pkg::TIMER_MAX
                                                         : sum[kst_pkg::TIMER_BITS-1:0];
               end
            end
         end
         kst_pkg::MODE_QLEVEL: begin
            if (ok) begin
               if (!it.keep_fresh) key_fresh[k] = 1'b0;
               ans = key_level[k];
            end
         end
         kst_pkg::MODE_QFRESH: begin
            if (ok) ans = take_fresh_press(k);
         end
         kst_pkg::MODE_QHELD: begin
            if (ok) begin
               if (take_fresh_press(k)) begin
                  ans = 1'b1;
               end else if (key_hold[k] >= it.hold_limit) begin
                  key_hold[k] = '0;
                  ans = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic plan_row_type row(logic [2:0] mode, logic [6:0] key, logic down,
                                        logic keep, logic [15:0] dt, logic [31:0] limit,
                                        bit typed, bit answer);
      plan_row_type r;
      r.item = '{mode, key, down, keep, dt, limit};
      r.typed = typed;
      r.answer = answer;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic key_item_type random_item();
      key_item_type it;
      int r;
      int lr;
      it.key_index = ($urandom_range(0, 99) < 80) ? hot_keys[$urandom_range(0, 5)]
                                                   : 7'($urandom_range(0, 127));
      it.key_down = 1'($urandom);
      it.keep_fresh = 1'($urandom);
      it.elapsed_ticks = 16'($urandom);
      it.hold_limit = $urandom;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         it.mode = kst_pkg::MODE_SET;
      end else if (r < 36) begin
         it.mode = kst_pkg::MODE_TICK;
         if ($urandom_range(0, 3) != 0) it.elapsed_ticks = 16'($urandom_range(0, 2000));
      end else if (r < 50) begin
         it.mode = kst_pkg::MODE_QLEVEL;
      end else if (r < 65) begin
         it.mode = kst_pkg::MODE_QFRESH;
      end else if (r < 95) begin
         it.mode = kst_pkg::MODE_QHELD;
         lr = $urandom_range(0, 9);
         if (lr == 0) it.hold_limit = '0;
         else if (lr == 1) it.hold_limit = '1;
         else if (lr > 2) it.hold_limit = $urandom_range(0, 6000);
      end else begin
         it.mode = 3'(int'(kst_pkg::MODE_QHELD) + $urandom_range(1, 3));
      end
      return it;
   endfunction

   // offer one beat; req_tvalid stays high into the next item when there is no gap
   task automatic offer_item(key_item_type it, bit typed, bit answer);
      int gap;
      bit predicted;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {7'd0, it.hold_limit, it.elapsed_ticks, it.keep_fresh, it.key_down,
                    it.key_index};
      do @(posedge clock); while (!req_tready);
      predicted = key_table_answer(it);
      pending_answers.push_back(typed ? answer : predicted);
      items_taken++;
   endtask

   // stimulus
   initial begin
      int waited;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = kst_pkg::MODE_SET;
      items_taken = 0;
      errors = 0;
      for (int i = 0; i < kst_pkg::KEY_COUNT; i++) begin
         key_level[i] = 1'b0;
         key_fresh[i] = 1'b0;
         key_hold[i] = '0;
      end
      for (int i = 0; i < 6; i++) hot_keys[i] = 7'($urandom_range(0, 127));

      plan.push_back(row(kst_pkg::MODE_QLEVEL, 7'd0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QFRESH, 7'd127, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                         1'b1, 1'b0));
      // zero hold limit matches even on a released key
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd5, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b1));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd5, 1'b0, 1'b0, 16'h0000, 32'hFFFF_FFFF,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_SET, 7'd127, 1'b1, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QLEVEL, 7'd127, 1'b0, 1'b1, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b1));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd127, 1'b0, 1'b0, 16'h0000, 32'hFFFF_FFFF,
                         1'b1, 1'b1));
      plan.push_back(row(kst_pkg::MODE_QFRESH, 7'd127, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0, 16'hFFFF, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd127, 1'b0, 1'b0, 16'h0000, 32'h0000_FFFF,
                         1'b1, 1'b1));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd127, 1'b0, 1'b0, 16'h0000, 32'h0000_0001,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_TICK, 7'd127, 1'b1, 1'b1, 16'h0000, 32'hFFFF_FFFF,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_SET, 7'd127, 1'b1, 1'b1, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QFRESH, 7'd127, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_SET, 7'd0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QLEVEL, 7'd0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b1));
      plan.push_back(row(kst_pkg::MODE_QFRESH, 7'd0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      // release raises fresh, but a fresh press needs the key down
      plan.push_back(row(kst_pkg::MODE_SET, 7'd0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QFRESH, 7'd0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QLEVEL, 7'd0, 1'b0, 1'b1, 16'h0000, 32'h0000_0000,
                         1'b1, 1'b0));
      plan.push_back(row(3'(int'(kst_pkg::MODE_QHELD) + 3), 7'd127, 1'b1, 1'b1, 16'hFFFF,
                         32'hFFFF_FFFF, 1'b1, 1'b0));
      plan.push_back(row(3'(int'(kst_pkg::MODE_QHELD) + 1), 7'd64, 1'b0, 1'b0, 16'h0000,
                         32'h0000_0000, 1'b1, 1'b0));
      plan.push_back(row(kst_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0, 16'd1234, 32'h0000_0000,
                         1'b0, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd127, 1'b0, 1'b0, 16'h0000, 32'd1234,
                         1'b0, 1'b0));
      plan.push_back(row(kst_pkg::MODE_QHELD, 7'd127, 1'b0, 1'b0, 16'h0000, 32'hFFFF_FFFF,
                         1'b1, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) offer_item(plan[i].item, plan[i].typed, plan[i].answer);
      for (int n = 0; n < 650; n++) offer_item(random_item(), 1'b0, 1'b0);
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_answers.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d answers never arrived", pending_answers.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // long receiver hold-off so the block backs up onto its input
   initial begin
      hold_off = 1'b0;
      wait (items_taken >= 60);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   // result side: check each beat, then pick the next ready pattern
   initial begin
      int stall_left;
      int run_left;
      bit expected;
      rsp_tready = 1'b0;
      stall_left = 0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               $error("result beat with no answer expected, answer %0d", rsp_tdata[0]);
               errors++;
            end else begin
               expected = pending_answers.pop_front();
               if (rsp_tdata[0] !== expected) begin
                  $error("answer mismatch: expected %0d, got %0d", expected, rsp_tdata[0]);
                  errors++;
               end
            end
         end
         if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               stall_left = 0;
               run_left = $urandom_range(50, 150);
            end else begin
               stall_left = idle_cycles();
               run_left = $urandom_range(1, 20);
            end
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            run_left--;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/kst_pkg.sv
rtl/kst_dpath.sv
rtl/kst_ctrl.sv
rtl/key_state_edge_and_repeat_table.sv
bench/testbench.sv
